@@ sv/bcld_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcld_pkg: shared types and constants of the button click detector
// Field widths, register codes, event codes, per-key phase encoding and the
// item record that travels from the front end through the queue to the back.
// ----------------------------------------------------------------------------
package bcld_pkg;

    localparam int KEY_W     = 3;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int RES_W     = 2;

    localparam int NUM_KEYS  = 8;
    localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // item queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1500;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_LONG_PRESS   = 2'd1,
        REG_DOUBLE_CLICK = 2'd2
    } reg_idx_t;

    typedef enum logic [RES_W-1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'b00001,
        PH_DEB_PRESS   = 5'b00010,
        PH_PRESSED     = 5'b00100,
        PH_DEB_RELEASE = 5'b01000,
        PH_WAIT_DOUBLE = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              in_range;
        logic              down;
        logic [TIME_W-1:0] now;
    } item_t;

endpackage
`default_nettype wire

@@ sv/bcld_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcld_front: input stage
// Registers each scan sample, flags keys outside the table and hands the
// item on to the queue.
// ----------------------------------------------------------------------------
module bcld_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [bcld_pkg::KEY_W-1:0]  s_key_index,
    input  wire logic                        s_level,
    input  wire logic [bcld_pkg::TIME_W-1:0] s_now_ms,
    output logic                             q_valid,
    input  wire logic                        q_ready,
    output bcld_pkg::item_t                  q_item
);

    logic            valid_reg;
    logic            valid_next;
    bcld_pkg::item_t item_reg;
    bcld_pkg::item_t item_next;
    logic            s_accept;

    assign s_ready  = !valid_reg || q_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        item_next.key      = s_key_index;
        item_next.in_range = (32'(s_key_index) < bcld_pkg::NUM_KEYS);
        item_next.down     = s_level;
        item_next.now      = s_now_ms;
        valid_next         = s_accept || (valid_reg && !q_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule
`default_nettype wire

@@ sv/bcld_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcld_queue: item queue
// Small first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
module bcld_queue (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  wire bcld_pkg::item_t wr_item,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output bcld_pkg::item_t rd_item
);

    bcld_pkg::item_t                 mem [bcld_pkg::Q_DEPTH];
    logic [bcld_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [bcld_pkg::Q_PTR_W-1:0]    wr_ptr_next;
    logic [bcld_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [bcld_pkg::Q_PTR_W-1:0]    rd_ptr_next;
    logic [bcld_pkg::Q_CNT_W-1:0]    cnt_reg;
    logic [bcld_pkg::Q_CNT_W-1:0]    cnt_next;
    logic                            push;
    logic                            pop;

    assign wr_ready = (cnt_reg != bcld_pkg::Q_CNT_W'(bcld_pkg::Q_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == bcld_pkg::Q_DEPTH - 1) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == bcld_pkg::Q_DEPTH - 1) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
`default_nettype wire

@@ sv/bcld_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcld_back: per-key state machines
// Holds the timing registers and the per-key state, runs one key's machine
// per item as a read-modify-write and registers the result.
// ----------------------------------------------------------------------------
module bcld_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr,
    input  wire logic [bcld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcld_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire bcld_pkg::item_t               q_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bcld_pkg::KEY_W-1:0]         m_event_key,
    output logic [bcld_pkg::RES_W-1:0]         m_event_res
);

    localparam int TW = bcld_pkg::TIME_W;

    logic [bcld_pkg::CFG_W-1:0] debounce_reg;
    logic [bcld_pkg::CFG_W-1:0] long_press_reg;
    logic [bcld_pkg::CFG_W-1:0] double_click_reg;

    bcld_pkg::phase_t phase_reg       [bcld_pkg::NUM_KEYS];
    logic [TW-1:0]    phase_start_reg [bcld_pkg::NUM_KEYS];
    logic [TW-1:0]    release_reg     [bcld_pkg::NUM_KEYS];
    logic [TW-1:0]    press_start_reg [bcld_pkg::NUM_KEYS];
    logic             long_rep_reg    [bcld_pkg::NUM_KEYS];

    logic [bcld_pkg::KEY_IDX_W-1:0] idx;
    bcld_pkg::phase_t phase_next;
    logic [TW-1:0]    phase_start_next;
    logic [TW-1:0]    release_next;
    logic [TW-1:0]    press_start_next;
    logic             long_rep_next;
    bcld_pkg::event_t ev;

    logic [TW-1:0] el_phase;
    logic [TW-1:0] el_press;
    logic [TW-1:0] el_release;
    logic          deb_done;
    logic          long_due;
    logic          dbl_inside;
    logic          dbl_expired;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [bcld_pkg::KEY_W-1:0] out_key_reg;
    logic [bcld_pkg::RES_W-1:0] out_res_reg;
    logic                       pop;

    assign pop     = q_valid && (!out_valid_reg || m_ready);
    assign q_ready = pop;
    assign idx     = q_item.key[bcld_pkg::KEY_IDX_W-1:0];

    // elapsed times, all modulo 2^32
    assign el_phase    = q_item.now - phase_start_reg[idx];
    assign el_press    = q_item.now - press_start_reg[idx];
    assign el_release  = q_item.now - release_reg[idx];
    assign deb_done    = (el_phase >= TW'(debounce_reg));
    assign long_due    = (el_press >= TW'(long_press_reg));
    assign dbl_inside  = (el_release <= TW'(double_click_reg));
    assign dbl_expired = (el_release >= TW'(double_click_reg));

    always_comb begin
        phase_next       = phase_reg[idx];
        phase_start_next = phase_start_reg[idx];
        release_next     = release_reg[idx];
        press_start_next = press_start_reg[idx];
        long_rep_next    = long_rep_reg[idx];
        ev               = bcld_pkg::EV_NONE;
        case (phase_reg[idx])
            bcld_pkg::PH_DEB_PRESS: begin
                if (q_item.down) begin
                    if (deb_done) begin
                        phase_next       = bcld_pkg::PH_PRESSED;
                        phase_start_next = q_item.now;
                        press_start_next = q_item.now;
                        long_rep_next    = 1'b0;
                    end
                end else begin
                    phase_next = bcld_pkg::PH_IDLE;
                end
            end
            bcld_pkg::PH_PRESSED: begin
                if (!q_item.down) begin
                    phase_start_next = q_item.now;
                    phase_next       = bcld_pkg::PH_DEB_RELEASE;
                end else if (!long_rep_reg[idx] && long_due) begin
                    ev            = bcld_pkg::EV_LONG;
                    long_rep_next = 1'b1;
                end
            end
            bcld_pkg::PH_DEB_RELEASE: begin
                if (!q_item.down) begin
                    if (deb_done) begin
                        if (!long_due) begin
                            release_next = q_item.now;
                            phase_next   = bcld_pkg::PH_WAIT_DOUBLE;
                        end else begin
                            phase_next = bcld_pkg::PH_IDLE;
                        end
                    end
                end else begin
                    // bounce: back to held, press start kept
                    phase_next = bcld_pkg::PH_PRESSED;
                end
            end
            bcld_pkg::PH_WAIT_DOUBLE: begin
                if (q_item.down) begin
                    ev = dbl_inside ? bcld_pkg::EV_DOUBLE : bcld_pkg::EV_SINGLE;
                    phase_next       = bcld_pkg::PH_DEB_PRESS;
                    phase_start_next = q_item.now;
                end else if (dbl_expired) begin
                    ev         = bcld_pkg::EV_SINGLE;
                    phase_next = bcld_pkg::PH_IDLE;
                end
            end
            default: begin
                if (q_item.down) begin
                    phase_start_next = q_item.now;
                    phase_next       = bcld_pkg::PH_DEB_PRESS;
                end else begin
                    phase_next = bcld_pkg::PH_IDLE;
                end
            end
        endcase
        if (!q_item.in_range) begin
            ev = bcld_pkg::EV_NONE;
        end
    end

    always_comb begin
        out_valid_next = pop || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg     <= bcld_pkg::DEBOUNCE_RST;
            long_press_reg   <= bcld_pkg::LONG_PRESS_RST;
            double_click_reg <= bcld_pkg::DOUBLE_CLICK_RST;
        end else if (cfg_wr) begin
            case (cfg_index)
                bcld_pkg::REG_DEBOUNCE:     debounce_reg     <= cfg_data;
                bcld_pkg::REG_LONG_PRESS:   long_press_reg   <= cfg_data;
                bcld_pkg::REG_DOUBLE_CLICK: double_click_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < bcld_pkg::NUM_KEYS; k++) begin
                phase_reg[k]       <= bcld_pkg::PH_IDLE;
                phase_start_reg[k] <= '0;
                release_reg[k]     <= '0;
                press_start_reg[k] <= '0;
                long_rep_reg[k]    <= 1'b0;
            end
        end else if (pop && q_item.in_range) begin
            phase_reg[idx]       <= phase_next;
            phase_start_reg[idx] <= phase_start_next;
            release_reg[idx]     <= release_next;
            press_start_reg[idx] <= press_start_next;
            long_rep_reg[idx]    <= long_rep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_key_reg <= q_item.key;
            out_res_reg <= ev;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_event_key = out_key_reg;
    assign m_event_res = out_res_reg;

endmodule
`default_nettype wire

@@ sv/button_click_long_double_detector.sv @@
// path: front input register, queue, then the back end's result register
// throughput: one sample per cycle while m_ready stays high; each key's
//   state is read, updated and written back by the back end
// a stalled result port fills the two-entry queue, then s_ready drops
// reset (aresetn low, synchronous): every key idle, timing registers back
//   to 30 / 1500 / 100 ms, queue and output empty
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_long_double_detector: top level
// Per-key debounce, single click, double click and long press detection on
// a stream of timestamped scan samples.
// ----------------------------------------------------------------------------
module button_click_long_double_detector (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bcld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcld_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [bcld_pkg::KEY_W-1:0]     s_key_index,
    input  wire logic                           s_level,
    input  wire logic [bcld_pkg::TIME_W-1:0]    s_now_ms,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [bcld_pkg::KEY_W-1:0]          m_event_key,
    output logic [bcld_pkg::RES_W-1:0]          m_event_res
);

    logic            fq_valid;
    logic            fq_ready;
    bcld_pkg::item_t fq_item;
    logic            qb_valid;
    logic            qb_ready;
    bcld_pkg::item_t qb_item;
    logic            cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    bcld_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_index (s_key_index),
        .s_level     (s_level),
        .s_now_ms    (s_now_ms),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_item      (fq_item)
    );

    bcld_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    bcld_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr      (cfg_wr),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_item      (qb_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_key (m_event_key),
        .m_event_res (m_event_res)
    );

endmodule
`default_nettype wire

@@ sv/bcld_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcld_checker: port-level checks
// Watches the top level's ports and flags reset and flow-control slips.
// ----------------------------------------------------------------------------
module bcld_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           cfg_ready,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [bcld_pkg::KEY_W-1:0]     m_event_key,
    input wire logic [bcld_pkg::RES_W-1:0]     m_event_res
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_key) && $stable(m_event_res))
        else $error("result changed while stalled");

    // reset empties the result register
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // reset leaves the input stage free
    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // register writes never stall
    a_cfg_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind button_click_long_double_detector bcld_checker u_bcld_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_ready   (cfg_ready),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_event_key (m_event_key),
    .m_event_res (m_event_res)
);
`default_nettype wire
